FILE: rtl/core/llhc_pkg.sv
// Shared types and constants for the light level hysteresis classifier.
// Depends on nothing; used by every module under rtl/core.
package llhc_pkg;

  localparam int unsigned LuxW  = 17;
  localparam int unsigned FracW = 8;
  localparam int unsigned AvgW  = LuxW + FracW;
  localparam int unsigned WgtW  = 8;
  localparam int unsigned IdxW  = 3;

  // Fixed band edges for the first classification after reset or after a missing reading.
  localparam logic [LuxW-1:0] BandSoft   = 17'd300;
  localparam logic [LuxW-1:0] BandBright = 17'd3000;
  localparam logic [LuxW-1:0] BandStrong = 17'd10000;

  // Register reset values.
  localparam logic [WgtW-1:0] RstWeight     = 8'd31;
  localparam logic [LuxW-1:0] RstRiseSoft   = 17'd350;
  localparam logic [LuxW-1:0] RstFallDim    = 17'd250;
  localparam logic [LuxW-1:0] RstRiseBright = 17'd3500;
  localparam logic [LuxW-1:0] RstFallSoft   = 17'd2500;
  localparam logic [LuxW-1:0] RstRiseStrong = 17'd11500;
  localparam logic [LuxW-1:0] RstFallBright = 17'd8500;

  typedef enum logic [IdxW-1:0] {
    REG_EMA_WEIGHT   = 3'd0,
    REG_RISE_SOFT    = 3'd1,
    REG_FALL_DIM     = 3'd2,
    REG_RISE_BRIGHT  = 3'd3,
    REG_FALL_SOFT    = 3'd4,
    REG_RISE_STRONG  = 3'd5,
    REG_FALL_BRIGHT  = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    LVL_DIM    = 2'd0,
    LVL_SOFT   = 2'd1,
    LVL_BRIGHT = 2'd2,
    LVL_STRONG = 2'd3
  } level_e;

  typedef struct packed {
    logic [WgtW-1:0] ema_weight;
    logic [LuxW-1:0] rise_dim_to_soft;
    logic [LuxW-1:0] fall_soft_to_dim;
    logic [LuxW-1:0] rise_soft_to_bright;
    logic [LuxW-1:0] fall_bright_to_soft;
    logic [LuxW-1:0] rise_bright_to_strong;
    logic [LuxW-1:0] fall_strong_to_bright;
  } cfg_t;

  typedef struct packed {
    level_e          light_level;
    logic            level_valid;
    logic            level_changed;
    logic [LuxW-1:0] average_lux;
  } result_t;

endpackage

FILE: rtl/core/light_level_hysteresis_classifier.sv
// Top level of the light level hysteresis classifier.
// Depends on llhc_pkg, llhc_cfg_regs and llhc_state.
//
// Usage:
//   Input channel: in_valid_i with lux_sample_i and sample_valid_i; a word is
//   taken at a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: out_valid_o with light_level_o, level_valid_o,
//   level_changed_o and average_lux_o; a word leaves at an edge with
//   out_valid_o high and out_stall_i low.
//   Configuration: cfg_valid_i, cfg_index_i, cfg_data_i; cfg_ready_o is
//   always high, so a write lands at any edge with cfg_valid_i high.
//   Write registers only while no word is in flight.
// Timing:
//   A word passes the input register, then the average update and level
//   decision into the result register.
//   Throughput is one word per cycle while out_stall_i is low; the state loop
//   through the weight multiply, add and threshold compares sets that rate.
// Reset clears the average, the ready flag, the held level (dim), both
// pipeline valid flags, and loads the register defaults.
// A stalled receiver holds the result register; an empty input register takes
// one more word, and while both registers are full in_stall_o follows out_stall_i.
module light_level_hysteresis_classifier
  import llhc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [LuxW-1:0] lux_sample_i,
  input  logic            sample_valid_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      light_level_o,
  output logic            level_valid_o,
  output logic            level_changed_o,
  output logic [LuxW-1:0] average_lux_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [IdxW-1:0] cfg_index_i,
  input  logic [LuxW-1:0] cfg_data_i
);

  cfg_t            cfg;
  result_t         result;

  logic            s1_valid_q;
  logic [LuxW-1:0] s1_lux_q;
  logic            s1_sv_q;
  logic            out_valid_q;
  result_t         out_q;

  logic            out_free;
  logic            advance;
  logic            in_take;

  assign cfg_ready_o = 1'b1;

  llhc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_lux_q <= lux_sample_i;
      s1_sv_q  <= sample_valid_i;
    end
  end

  llhc_state u_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .upd_en_i       (advance),
    .lux_i          (s1_lux_q),
    .sample_valid_i (s1_sv_q),
    .cfg_i          (cfg),
    .result_o       (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign light_level_o   = out_q.light_level;
  assign level_valid_o   = out_q.level_valid;
  assign level_changed_o = out_q.level_changed;
  assign average_lux_o   = out_q.average_lux;

endmodule

FILE: rtl/core/llhc_cfg_regs.sv
// Configuration register file: weight and the six hysteresis thresholds.
// Depends on llhc_pkg.
module llhc_cfg_regs
  import llhc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [IdxW-1:0]  cfg_index_i,
  input  logic [LuxW-1:0]  cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ema_weight            <= RstWeight;
      cfg_q.rise_dim_to_soft      <= RstRiseSoft;
      cfg_q.fall_soft_to_dim      <= RstFallDim;
      cfg_q.rise_soft_to_bright   <= RstRiseBright;
      cfg_q.fall_bright_to_soft   <= RstFallSoft;
      cfg_q.rise_bright_to_strong <= RstRiseStrong;
      cfg_q.fall_strong_to_bright <= RstFallBright;
    end else if (cfg_valid_i) begin
      // indexes beyond the list are dropped
      unique case (cfg_index_i)
        REG_EMA_WEIGHT:  cfg_q.ema_weight            <= cfg_data_i[WgtW-1:0];
        REG_RISE_SOFT:   cfg_q.rise_dim_to_soft      <= cfg_data_i;
        REG_FALL_DIM:    cfg_q.fall_soft_to_dim      <= cfg_data_i;
        REG_RISE_BRIGHT: cfg_q.rise_soft_to_bright   <= cfg_data_i;
        REG_FALL_SOFT:   cfg_q.fall_bright_to_soft   <= cfg_data_i;
        REG_RISE_STRONG: cfg_q.rise_bright_to_strong <= cfg_data_i;
        REG_FALL_BRIGHT: cfg_q.fall_strong_to_bright <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/llhc_classify.sv
// Level decision: fixed bands on the first word after reset or after a missing reading, hysteresis steps after.
// Depends on llhc_pkg.
module llhc_classify
  import llhc_pkg::*;
(
  input  cfg_t            cfg_i,
  input  logic [LuxW-1:0] avg_int_i,
  input  level_e          prev_level_i,
  input  logic            prev_ready_i,
  output level_e          level_o
);

  // avg >= thr*256 holds exactly when the integer part is >= thr
  always_comb begin
    level_o = LVL_DIM;
    if (!prev_ready_i) begin
      priority if (avg_int_i < BandSoft)   level_o = LVL_DIM;
      else if (avg_int_i < BandBright)     level_o = LVL_SOFT;
      else if (avg_int_i < BandStrong)     level_o = LVL_BRIGHT;
      else                                 level_o = LVL_STRONG;
    end else begin
      unique case (prev_level_i)
        LVL_DIM: begin
          level_o = (avg_int_i >= cfg_i.rise_dim_to_soft) ? LVL_SOFT : LVL_DIM;
        end
        LVL_SOFT: begin
          priority if (avg_int_i < cfg_i.fall_soft_to_dim)        level_o = LVL_DIM;
          else if (avg_int_i >= cfg_i.rise_soft_to_bright)        level_o = LVL_BRIGHT;
          else                                                    level_o = LVL_SOFT;
        end
        LVL_BRIGHT: begin
          priority if (avg_int_i < cfg_i.fall_bright_to_soft)     level_o = LVL_SOFT;
          else if (avg_int_i >= cfg_i.rise_bright_to_strong)      level_o = LVL_STRONG;
          else                                                    level_o = LVL_BRIGHT;
        end
        LVL_STRONG: begin
          level_o = (avg_int_i < cfg_i.fall_strong_to_bright) ? LVL_BRIGHT : LVL_STRONG;
        end
        default: level_o = LVL_DIM;
      endcase
    end
  end

endmodule

FILE: rtl/core/llhc_state.sv
// Smoothed average, ready flag and held level, with their update logic.
// Depends on llhc_pkg and llhc_classify.
module llhc_state
  import llhc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            upd_en_i,
  input  logic [LuxW-1:0] lux_i,
  input  logic            sample_valid_i,
  input  cfg_t            cfg_i,
  output result_t         result_o
);

  logic [AvgW-1:0]   avg_q, avg_d;
  logic              ready_q, ready_d;
  level_e            level_q, level_d, level_cls;

  logic signed [AvgW:0]        delta;
  logic signed [AvgW+WgtW+1:0] prod;
  logic signed [AvgW+WgtW+1:0] prod_r;
  logic signed [AvgW+1:0]      step;
  logic signed [AvgW+2:0]      sum;
  logic [AvgW-1:0]             avg_upd;

  // step = floor((delta*w + 128) / 256)
  assign delta  = $signed({1'b0, lux_i, {FracW{1'b0}}}) - $signed({1'b0, avg_q});
  assign prod   = delta * $signed({1'b0, cfg_i.ema_weight});
  assign prod_r = prod + $signed({{(AvgW+WgtW+2-FracW){1'b0}}, 1'b1, {(FracW-1){1'b0}}});
  assign step   = prod_r[AvgW+WgtW+1:FracW];
  assign sum    = $signed({3'b000, avg_q}) + $signed({step[AvgW+1], step});

  // clamp at zero
  assign avg_upd = sum[AvgW+2] ? '0 : sum[AvgW-1:0];

  always_comb begin
    if (!sample_valid_i) begin
      avg_d = '0;
    end else if (!ready_q) begin
      avg_d = {lux_i, {FracW{1'b0}}};
    end else begin
      avg_d = avg_upd;
    end
  end

  llhc_classify u_classify (
    .cfg_i        (cfg_i),
    .avg_int_i    (avg_d[AvgW-1:FracW]),
    .prev_level_i (level_q),
    .prev_ready_i (ready_q),
    .level_o      (level_cls)
  );

  // a missing reading keeps the held level
  assign level_d = sample_valid_i ? level_cls : level_q;
  assign ready_d = sample_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q   <= '0;
      ready_q <= 1'b0;
      level_q <= LVL_DIM;
    end else if (upd_en_i) begin
      avg_q   <= avg_d;
      ready_q <= ready_d;
      level_q <= level_d;
    end
  end

  always_comb begin
    result_o.light_level   = ready_d ? level_d : LVL_DIM;
    result_o.level_valid   = ready_d;
    result_o.level_changed = (ready_q != ready_d) ||
                             (ready_q && ready_d && (level_q != level_d));
    result_o.average_lux   = ready_d ? avg_d[AvgW-1:FracW] : '0;
  end

endmodule
